// ----- hdl/gbn_sw_pkg.sv -----
`default_nettype none
package gbn_sw_pkg;

  // defaults for the top-level parameters
  localparam int SEQ_SPACE_DEF = 8;
  localparam int WINDOW_DEF    = 4;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  // input commands
  localparam logic [1:0] CMD_SEND   = 2'd0;
  localparam logic [1:0] CMD_ACK    = 2'd1;
  localparam logic [1:0] CMD_EXPIRE = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_REFUSE = 3'd0;
  localparam logic [2:0] KIND_TX     = 3'd1;
  localparam logic [2:0] KIND_START  = 3'd2;
  localparam logic [2:0] KIND_STOP   = 3'd3;
  localparam logic [2:0] KIND_IGNORE = 3'd4;

  // which result the datapath builds on an emit
  localparam logic [3:0] OP_REFUSE     = 4'd0;
  localparam logic [3:0] OP_SEND_TX    = 4'd1;
  localparam logic [3:0] OP_SEND_START = 4'd2;
  localparam logic [3:0] OP_ACK_STOP   = 4'd3;
  localparam logic [3:0] OP_ACK_START  = 4'd4;
  localparam logic [3:0] OP_IGNORE     = 4'd5;
  localparam logic [3:0] OP_EXP_STOP   = 4'd6;
  localparam logic [3:0] OP_EXP_START  = 4'd7;
  localparam logic [3:0] OP_RETX       = 4'd8;

  typedef struct packed {
    logic       accept;    // latch the input word
    logic       emit;      // load the output register
    logic [3:0] op;
    logic       last;      // final result; commits the state update
    logic       rd_start;  // load retransmit pointer and count
    logic       rd;        // read buffer at retransmit pointer
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       waiting;
    logic       base_eq_next;
    logic       ack_acc;
    logic       new_base_eq_next;
    logic       cnt_zero;
    logic       cnt_one;
    logic       out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- hdl/gbn_sw_ctrl.sv -----
`default_nettype none
module gbn_sw_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire gbn_sw_pkg::dp_status_t sts,
  output gbn_sw_pkg::ctrl_cmd_t       cmd
);
  import gbn_sw_pkg::*;

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_EVAL       = 4'd1;
  localparam logic [3:0] S_REFUSE     = 4'd2;
  localparam logic [3:0] S_SEND_TX    = 4'd3;
  localparam logic [3:0] S_SEND_START = 4'd4;
  localparam logic [3:0] S_ACK_STOP   = 4'd5;
  localparam logic [3:0] S_ACK_START  = 4'd6;
  localparam logic [3:0] S_IGNORE     = 4'd7;
  localparam logic [3:0] S_EXP_STOP   = 4'd8;
  localparam logic [3:0] S_EXP_START  = 4'd9;
  localparam logic [3:0] S_RD         = 4'd10;
  localparam logic [3:0] S_RETX       = 4'd11;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.op       = OP_REFUSE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        unique case (sts.cmd)
          CMD_SEND:   state_next = sts.waiting ? S_REFUSE : S_SEND_TX;
          CMD_ACK:    state_next = sts.ack_acc ? S_ACK_STOP : S_IGNORE;
          CMD_EXPIRE: begin
            cmd.rd_start = 1'b1;
            state_next   = S_EXP_STOP;
          end
          default:    state_next = S_IDLE;   // unused command, no result
        endcase
      end
      S_REFUSE: begin
        cmd.op = OP_REFUSE;
        cmd.last = 1'b1;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SEND_TX: begin
        cmd.op   = OP_SEND_TX;
        cmd.last = !sts.base_eq_next;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.base_eq_next ? S_SEND_START : S_IDLE;
        end
      end
      S_SEND_START: begin
        cmd.op   = OP_SEND_START;
        cmd.last = 1'b1;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ACK_STOP: begin
        cmd.op   = OP_ACK_STOP;
        cmd.last = sts.new_base_eq_next;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.new_base_eq_next ? S_IDLE : S_ACK_START;
        end
      end
      S_ACK_START: begin
        cmd.op   = OP_ACK_START;
        cmd.last = 1'b1;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_IGNORE: begin
        cmd.op   = OP_IGNORE;
        cmd.last = 1'b1;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EXP_STOP: begin
        cmd.op = OP_EXP_STOP;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_EXP_START;
        end
      end
      S_EXP_START: begin
        cmd.op   = OP_EXP_START;
        cmd.last = sts.cnt_zero;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.cnt_zero ? S_IDLE : S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_RETX;
      end
      S_RETX: begin
        cmd.op   = OP_RETX;
        cmd.last = sts.cnt_one;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.cnt_one ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/gbn_sw_dp.sv -----
`default_nettype none
module gbn_sw_dp #(
  parameter int SEQ_SPACE = gbn_sw_pkg::SEQ_SPACE_DEF,
  parameter int WINDOW    = gbn_sw_pkg::WINDOW_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [15:0]           cfg_wr_data,
  input  wire logic [1:0]            cmd,
  input  wire logic [63:0]           payload,
  input  wire logic [2:0]            ack_num,
  input  wire logic                  ack_valid,
  input  wire logic [2:0]            expired_seq,
  input  wire gbn_sw_pkg::ctrl_cmd_t ctl,
  output gbn_sw_pkg::dp_status_t     sts,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [2:0]                 kind,
  output logic [2:0]                 seq,
  output logic [63:0]                data_out,
  output logic [15:0]                timer_period,
  output logic                       window_full,
  output logic                       last
);
  import gbn_sw_pkg::*;

  localparam int SEQ_W = $clog2(SEQ_SPACE);
  localparam int WIN   = (WINDOW < SEQ_SPACE) ? WINDOW : SEQ_SPACE - 1;
  localparam logic [SEQ_W-1:0] WIN_L = SEQ_W'(WIN);

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] x);
    if (x == SEQ_W'(SEQ_SPACE - 1)) begin
      return '0;
    end
    return x + 1'b1;
  endfunction

  // (to - from) mod SEQ_SPACE
  function automatic logic [SEQ_W-1:0] seq_dist(input logic [SEQ_W-1:0] to,
                                                input logic [SEQ_W-1:0] from);
    logic [SEQ_W:0] t;
    t = {1'b0, to} + (SEQ_W + 1)'(SEQ_SPACE) - {1'b0, from};
    if (to >= from) begin
      return to - from;
    end
    return t[SEQ_W-1:0];
  endfunction

  logic [SEQ_W-1:0] base, nxt;
  logic             waiting;
  logic [15:0]      period;

  logic [1:0]       l_cmd;
  logic [63:0]      l_payload;
  logic [2:0]       l_ack;
  logic             l_ack_ok;
  logic [2:0]       l_exp;

  logic [63:0]      mem [SEQ_SPACE];
  logic [63:0]      rd_data;
  logic [SEQ_W-1:0] rp, cnt;

  logic [SEQ_W-1:0] dist_nb, nxt_inc, ack_s, new_base;
  logic             wait_send, ack_acc, waiting_after, send_ok;

  always_comb begin
    dist_nb   = seq_dist(nxt, base);
    nxt_inc   = seq_inc(nxt);
    wait_send = (seq_dist(nxt_inc, base) >= WIN_L);
    ack_s     = SEQ_W'(l_ack);
    new_base  = seq_inc(ack_s);
    ack_acc   = l_ack_ok && (32'(l_ack) < 32'(SEQ_SPACE))
                && (seq_dist(ack_s, base) < dist_nb);
    send_ok   = (l_cmd == CMD_SEND) && !waiting;
    priority if (send_ok) begin
      waiting_after = wait_send;
    end else if ((l_cmd == CMD_ACK) && ack_acc) begin
      waiting_after = 1'b0;
    end else begin
      waiting_after = waiting;
    end
  end

  always_comb begin
    sts                  = '0;
    sts.cmd              = l_cmd;
    sts.waiting          = waiting;
    sts.base_eq_next     = (base == nxt);
    sts.ack_acc          = ack_acc;
    sts.new_base_eq_next = (new_base == nxt);
    sts.cnt_zero         = (cnt == '0);
    sts.cnt_one          = (cnt == SEQ_W'(1));
    sts.out_free         = !out_valid || !out_stall;
  end

  // window state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      base    <= SEQ_W'(1);
      nxt     <= SEQ_W'(1);
      waiting <= 1'b0;
      period  <= TIMEOUT_RESET;
    end else begin
      if (cfg_wr_en) begin
        period <= cfg_wr_data;
      end
      if (ctl.emit && ctl.last) begin
        if (send_ok) begin
          nxt     <= nxt_inc;
          waiting <= wait_send;
        end else if ((l_cmd == CMD_ACK) && ack_acc) begin
          base    <= new_base;
          waiting <= 1'b0;
        end
      end
    end
  end

  // input word, retransmit pointer
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      l_cmd     <= cmd;
      l_payload <= payload;
      l_ack     <= ack_num;
      l_ack_ok  <= ack_valid;
      l_exp     <= expired_seq;
    end
    if (ctl.rd_start) begin
      rp  <= base;
      cnt <= dist_nb;
    end else if (ctl.emit && (ctl.op == OP_RETX)) begin
      rp  <= seq_inc(rp);
      cnt <= cnt - 1'b1;
    end
  end

  // unacknowledged buffer
  always_ff @(posedge clk) begin
    if (ctl.emit && ctl.last && send_ok) begin
      mem[nxt] <= l_payload;
    end
    if (ctl.rd) begin
      rd_data <= mem[rp];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      window_full  <= waiting_after;
      last         <= ctl.last;
      data_out     <= '0;
      timer_period <= '0;
      unique case (ctl.op)
        OP_REFUSE: begin
          kind <= KIND_REFUSE;
          seq  <= 3'(nxt);
        end
        OP_SEND_TX: begin
          kind     <= KIND_TX;
          seq      <= 3'(nxt);
          data_out <= l_payload;
        end
        OP_SEND_START: begin
          kind         <= KIND_START;
          seq          <= 3'(nxt);
          timer_period <= period;
        end
        OP_ACK_STOP: begin
          kind <= KIND_STOP;
          seq  <= 3'(base);
        end
        OP_ACK_START: begin
          kind         <= KIND_START;
          seq          <= 3'(new_base);
          timer_period <= period;
        end
        OP_IGNORE: begin
          kind <= KIND_IGNORE;
          seq  <= l_ack;
        end
        OP_EXP_STOP: begin
          kind <= KIND_STOP;
          seq  <= l_exp;
        end
        OP_EXP_START: begin
          kind         <= KIND_START;
          seq          <= l_exp;
          timer_period <= period;
        end
        OP_RETX: begin
          kind     <= KIND_TX;
          seq      <= 3'(rp);
          data_out <= rd_data;
        end
        default: begin
          kind <= KIND_REFUSE;
          seq  <= '0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/go_back_n_sender_window.sv -----
`default_nettype none
// Go-Back-N sender window. Keeps base and next sequence numbers (both 1 after
// reset, modulo SEQ_SPACE), a window-full flag and a buffer of unacknowledged
// payloads. cmd 0 sends a payload (refused while the window is full), cmd 1
// delivers an acknowledgment with its checksum verdict in ack_valid, cmd 2
// reports a timer expiry, cmd 3 is ignored and gives no result. Each other input
// word produces one or more result words, one per output handshake; last
// marks the final one and window_full gives the flag after that input.
// One input word is handled at a time: in_stall is high from acceptance
// until the last result has been loaded into the output register. A word
// is accepted, then decoded, then its results are loaded one by one while
// the output is not stalled. On a timer expiry each retransmission first
// reads the single-port payload buffer into a register and is then loaded
// into the output register. The output register lets a finished result
// wait while the next word is accepted. timeout_period is written through
// cfg_wr_en/cfg_wr_data, which the user must do only while idle (the block
// does not enforce this); it resets to 1000.
module go_back_n_sender_window #(
  parameter int SEQ_SPACE = gbn_sw_pkg::SEQ_SPACE_DEF,  // 2..8
  parameter int WINDOW    = gbn_sw_pkg::WINDOW_DEF      // capped at SEQ_SPACE-1
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: timeout_period
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  // input word
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [63:0] payload,
  input  wire logic [2:0]  ack_num,
  input  wire logic        ack_valid,
  input  wire logic [2:0]  expired_seq,
  // result word
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       kind,
  output logic [2:0]       seq,
  output logic [63:0]      data_out,
  output logic [15:0]      timer_period,
  output logic             window_full,
  output logic             last
);
  import gbn_sw_pkg::*;

  ctrl_cmd_t  ctl;
  dp_status_t sts;

  // sequencing of results per command
  gbn_sw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (ctl)
  );

  // window registers, payload buffer, output register
  gbn_sw_dp #(
    .SEQ_SPACE (SEQ_SPACE),
    .WINDOW    (WINDOW)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .cmd          (cmd),
    .payload      (payload),
    .ack_num      (ack_num),
    .ack_valid    (ack_valid),
    .expired_seq  (expired_seq),
    .ctl          (ctl),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .seq          (seq),
    .data_out     (data_out),
    .timer_period (timer_period),
    .window_full  (window_full),
    .last         (last)
  );

endmodule
`default_nettype wire

// ----- tb/gbn_window_checker.sv -----
module gbn_window_checker #(
  parameter int SEQ_SPACE = gbn_sw_pkg::SEQ_SPACE_DEF,
  parameter int WINDOW    = gbn_sw_pkg::WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [63:0] payload,
  input  logic [2:0]  ack_num,
  input  logic        ack_valid,
  input  logic [2:0]  expired_seq,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  kind,
  input  logic [2:0]  seq,
  input  logic [63:0] data_out,
  input  logic [15:0] timer_period,
  input  logic        window_full,
  input  logic        last,
  output int          fail_count,
  output int          pending,
  output int          win_base,
  output int          win_next,
  output int          words_seen,
  output int          results_seen,
  output int          refusals_seen,
  output int          resends_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import gbn_sw_pkg::*;

  // effective window, capped one below the sequence space
  localparam int WIN = (WINDOW < SEQ_SPACE) ? WINDOW : SEQ_SPACE - 1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  seq;
    logic [63:0] data;
    logic [15:0] period;
    logic        full;
    logic        last;
  } result_word_t;

  result_word_t expected_results[$];
  logic [63:0]  unacked_words [SEQ_SPACE];
  logic [15:0]  period_q = TIMEOUT_RESET;
  int           base_q = 1 % SEQ_SPACE;
  int           next_q = 1 % SEQ_SPACE;
  logic         full_q = 1'b0;
  int           fails = 0;
  int           words = 0;
  int           results = 0;
  int           refusals = 0;
  int           resends = 0;

  function automatic int seq_dist(int to, int from);
    return (to + SEQ_SPACE - from) % SEQ_SPACE;
  endfunction

  function automatic result_word_t make_result(logic [2:0] k, int s, logic [63:0] d,
                                               logic [15:0] p);
    result_word_t r;
    r.kind   = k;
    r.seq    = 3'(s);
    r.data   = d;
    r.period = p;
    r.full   = 1'b0;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic int field_mismatch(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // works out the result words of one command word and moves the window on
  task automatic step_sender_window(input logic [1:0] c, input logic [63:0] pl,
                                    input logic [2:0] an, input logic av,
                                    input logic [2:0] es);
    result_word_t burst[$];
    int           old_base;
    int           span;
    int           j;
    case (c)
      CMD_SEND: begin
        if (full_q) begin
          burst.push_back(make_result(KIND_REFUSE, next_q, '0, '0));
          refusals++;
        end else begin
          unacked_words[next_q] = pl;
          burst.push_back(make_result(KIND_TX, next_q, pl, '0));
          if (base_q == next_q)
            burst.push_back(make_result(KIND_START, next_q, '0, period_q));
          next_q = (next_q + 1) % SEQ_SPACE;
          if (seq_dist(next_q, base_q) >= WIN)
            full_q = 1'b1;
        end
      end
      CMD_ACK: begin
        if (av && int'(an) < SEQ_SPACE &&
            seq_dist(an, base_q) < seq_dist(next_q, base_q)) begin
          old_base = base_q;
          full_q   = 1'b0;
          base_q   = (an + 1) % SEQ_SPACE;
          burst.push_back(make_result(KIND_STOP, old_base, '0, '0));
          if (base_q != next_q)
            burst.push_back(make_result(KIND_START, base_q, '0, period_q));
        end else begin
          burst.push_back(make_result(KIND_IGNORE, an, '0, '0));
        end
      end
      CMD_EXPIRE: begin
        span = seq_dist(next_q, base_q);
        j    = base_q;
        burst.push_back(make_result(KIND_STOP, es, '0, '0));
        burst.push_back(make_result(KIND_START, es, '0, period_q));
        for (int i = 0; i < span; i++) begin
          burst.push_back(make_result(KIND_TX, j, unacked_words[j], '0));
          j = (j + 1) % SEQ_SPACE;
          resends++;
        end
      end
      default: ;
    endcase
    foreach (burst[i]) begin
      burst[i].full = full_q;
      burst[i].last = (i == burst.size() - 1);
      expected_results.push_back(burst[i]);
    end
  endtask

  task automatic check_result();
    result_word_t want;
    results++;
    if (expected_results.size() == 0) begin
      $error("result word with nothing expected: kind %0d seq %0d", kind, seq);
      fails++;
    end else begin
      want = expected_results.pop_front();
      fails += field_mismatch("kind", want.kind, kind);
      fails += field_mismatch("seq", want.seq, seq);
      fails += field_mismatch("data_out", want.data, data_out);
      fails += field_mismatch("timer_period", want.period, timer_period);
      fails += field_mismatch("window_full", want.full, window_full);
      fails += field_mismatch("last", want.last, last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      period_q = TIMEOUT_RESET;
      base_q   = 1 % SEQ_SPACE;
      next_q   = 1 % SEQ_SPACE;
      full_q   = 1'b0;
      expected_results.delete();
      foreach (unacked_words[i]) unacked_words[i] = '0;
    end else begin
      // results first, so a word arriving in the same cycle cannot mask a stray one
      if (out_valid && !out_stall)
        check_result();
      if (cfg_wr_en)
        period_q = cfg_wr_data;
      if (in_valid && !in_stall) begin
        words++;
        step_sender_window(cmd, payload, ack_num, ack_valid, expired_seq);
      end
    end
    fail_count    <= fails;
    pending       <= expected_results.size();
    win_base      <= base_q;
    win_next      <= next_q;
    words_seen    <= words;
    results_seen  <= results;
    refusals_seen <= refusals;
    resends_seen  <= resends;
  end

endmodule

// ----- tb/go_back_n_sender_window_tb.sv -----
module go_back_n_sender_window_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gbn_sw_pkg::*;

  localparam int SEQ_SPACE = SEQ_SPACE_DEF;
  localparam int WINDOW    = WINDOW_DEF;

  // cmd 3 has no meaning to the block: no result, no state change
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // cycles let pass after the last result before a register write or the
  // verdict; covers a cmd 3 word still being decoded
  localparam int DRAIN_CYCLES   = 16;
  // long output hold-off, enough to back the block up into its input
  localparam int HOLD_CYCLES    = 150;
  // cycles without any handshake before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = CMD_SEND;
  logic [63:0] payload = '0;
  logic [2:0]  ack_num = '0;
  logic        ack_valid = 1'b0;
  logic [2:0]  expired_seq = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [2:0]  seq;
  logic [63:0] data_out;
  logic [15:0] timer_period;
  logic        window_full;
  logic        last;

  int fail_count;
  int pending;
  int win_base;
  int win_next;
  int words_seen;
  int results_seen;
  int refusals_seen;
  int resends_seen;

  // idling odds in percent; the receiver reads its own under NBA timing
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  // each increment asks the receiver for one long hold-off
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  go_back_n_sender_window #(
    .SEQ_SPACE(SEQ_SPACE),
    .WINDOW   (WINDOW)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .payload     (payload),
    .ack_num     (ack_num),
    .ack_valid   (ack_valid),
    .expired_seq (expired_seq),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .seq         (seq),
    .data_out    (data_out),
    .timer_period(timer_period),
    .window_full (window_full),
    .last        (last)
  );

  gbn_window_checker #(
    .SEQ_SPACE(SEQ_SPACE),
    .WINDOW   (WINDOW)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .payload      (payload),
    .ack_num      (ack_num),
    .ack_valid    (ack_valid),
    .expired_seq  (expired_seq),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .seq          (seq),
    .data_out     (data_out),
    .timer_period (timer_period),
    .window_full  (window_full),
    .last         (last),
    .fail_count   (fail_count),
    .pending      (pending),
    .win_base     (win_base),
    .win_next     (win_next),
    .words_seen   (words_seen),
    .results_seen (results_seen),
    .refusals_seen(refusals_seen),
    .resends_seen (resends_seen)
  );

  // Result side. A pending hold-off request wins over the random stalls and
  // is counted down here, so the sender keeps offering words meanwhile.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Watchdog: only cycles with no handshake on either side count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("go_back_n_sender_window test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one command word, with random gaps first; held until taken.
  task automatic offer_word(input logic [1:0] c, input logic [63:0] pl,
                            input logic [2:0] an, input logic av, input logic [2:0] es);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    payload     <= pl;
    ack_num     <= an;
    ack_valid   <= av;
    expired_seq <= es;
    do @(posedge clk); while (in_stall);
  endtask

  // Sender goes quiet until every expected result word has come back.
  // The first edge lets the count take in a word accepted just now.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // timeout_period is only touched with the block idle
  task automatic set_timeout(input logic [15:0] v);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Random traffic, mostly well-formed: sends, acks aimed inside the
  // outstanding window, expiries of the base timer. The rest is bad
  // checksums, stray ack numbers, odd expiries and the unused command.
  // The window view from the checker may lag by one word; a stale ack just
  // lands outside and is ignored. cmd 3 words do not count towards n.
  task automatic run_traffic(input int n, input int pause_at, input int hold_at);
    int          done;
    int          r;
    int          span;
    logic [1:0]  c;
    logic [63:0] pl;
    logic [2:0]  an;
    logic        av;
    logic [2:0]  es;
    done = 0;
    while (done < n) begin
      if (done == pause_at)
        wait_drained();
      if (done == hold_at)
        hold_req <= hold_req + 1;
      r    = $urandom_range(99);
      span = (win_next - win_base + SEQ_SPACE) % SEQ_SPACE;
      pl   = {$urandom(), $urandom()};
      case ($urandom_range(15))
        0:       pl = '0;
        1:       pl = '1;
        default: ;
      endcase
      an = 3'($urandom_range(7));
      av = 1'b1;
      es = 3'($urandom_range(7));
      if (r < 45) begin
        c = CMD_SEND;
      end else if (r < 78) begin
        c = CMD_ACK;
        if (span > 0)
          an = 3'((win_base + $urandom_range(span - 1)) % SEQ_SPACE);
      end else if (r < 87) begin
        c  = CMD_ACK;
        av = 1'($urandom_range(1));
      end else if (r < 97) begin
        c = CMD_EXPIRE;
        if ($urandom_range(3) != 0)
          es = 3'(win_base);
      end else begin
        c = CMD_UNUSED;
      end
      offer_word(c, pl, an, av, es);
      if (c != CMD_UNUSED)
        done++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words at the reset timeout, with both sides idling.
    tx_idle_pct = 27;
    rx_idle_pct <= 68;
    offer_word(CMD_EXPIRE, '0, '0, 1'b0, 3'd7);          // expiry, nothing outstanding
    offer_word(CMD_ACK, '0, 3'd1, 1'b1, '0);             // ack of a packet not yet sent
    offer_word(CMD_UNUSED, '1, '1, 1'b1, '1);            // unused command, no result
    offer_word(CMD_SEND, 64'h0, '0, 1'b0, '0);           // first packet, timer starts
    offer_word(CMD_SEND, '1, '0, 1'b0, '0);
    offer_word(CMD_SEND, 64'hA5A5_A5A5_A5A5_A5A5, '0, 1'b0, '0);
    offer_word(CMD_SEND, 64'h5A5A_5A5A_5A5A_5A5A, '0, 1'b0, '0); // window now full
    offer_word(CMD_SEND, {$urandom(), $urandom()}, '0, 1'b0, '0); // refused
    offer_word(CMD_ACK, '0, 3'd2, 1'b0, '0);             // bad checksum
    offer_word(CMD_EXPIRE, '0, '0, 1'b0, 3'd1);          // full window resent, six results
    offer_word(CMD_ACK, '0, 3'd2, 1'b1, '0);             // slide to 3, timer restarts
    offer_word(CMD_ACK, '0, 3'd0, 1'b1, '0);             // behind the base, ignored
    offer_word(CMD_ACK, '0, 3'd4, 1'b1, '0);             // window empties, no restart
    repeat (4)                                           // 5, 6, 7, 0: wraps round
      offer_word(CMD_SEND, {$urandom(), $urandom()}, '0, 1'b0, '0);
    offer_word(CMD_EXPIRE, '0, '0, 1'b0, 3'd5);          // resend across the wrap
    offer_word(CMD_ACK, '0, 3'd6, 1'b1, '0);
    offer_word(CMD_ACK, '0, 3'd0, 1'b1, '0);             // ack past the wrap, empty
    offer_word(CMD_SEND, {$urandom(), $urandom()}, '0, 1'b0, '0);
    offer_word(CMD_UNUSED, '0, '0, 1'b0, '0);

    // Shortest timeout; sender idles lightly, receiver heavily.
    set_timeout(16'd1);
    run_traffic(50, -1, -1);

    // Longest timeout; idling swapped, with one full drain midway.
    set_timeout(16'hFFFF);
    tx_idle_pct = 68;
    rx_idle_pct <= 27;
    run_traffic(50, 30, -1);

    // Arbitrary timeout, no idling, and one long hold-off on the results
    // while words keep coming.
    set_timeout(16'($urandom_range(65534, 2)));
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    run_traffic(45, -1, 10);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d command words in, %0d result words checked (%0d refused sends, %0d resends)",
             words_seen, results_seen, refusals_seen, resends_seen);
    $display("four timeout settings, wrap of the sequence space, stalls and a long hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("go_back_n_sender_window test passed");
    end else begin
      $display("go_back_n_sender_window test failed");
    end
    $finish;
  end

endmodule

// ----- go_back_n_sender_window.f -----
hdl/gbn_sw_pkg.sv
hdl/gbn_sw_ctrl.sv
hdl/gbn_sw_dp.sv
hdl/go_back_n_sender_window.sv
tb/gbn_window_checker.sv
tb/go_back_n_sender_window_tb.sv
